// ----- hdl/ztp_pkg.sv -----
// Shared types and constants for the zone time profiler.
package ztp_pkg;

    localparam int unsigned ZONE_W   = 4;
    localparam int unsigned TS_W     = 32;
    localparam int unsigned MS_W     = 32;
    localparam int unsigned FRAC_W   = 17;
    localparam int unsigned ALPHA_W  = 17;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 32;
    localparam int unsigned DVD_W    = 64;

    localparam logic [31:0]        TPS_RESET   = 32'd46875000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd3277;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [FRAC_W-1:0]  FRAC_ONE    = 17'd65536;

    // Register indexes of the configuration port.
    localparam logic [CFG_AW-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_TPS    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_ALPHA  = 2'd2;

    typedef enum logic [1:0] {
        REQ_BEGIN  = 2'd0,
        REQ_END    = 2'd1,
        REQ_FRAME  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NO_BEGIN = 2'd2,
        ST_DISABLED = 2'd3
    } status_t;

endpackage

// ----- hdl/ztp_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module ztp_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ztp_pkg::DVD_W-1:0]   dividend,
    input  logic [31:0]                 divisor,
    output logic                        done,
    output logic [ztp_pkg::DVD_W-1:0]   quotient
);

    localparam int unsigned CW = $clog2(ztp_pkg::DVD_W + 1);

    logic                      busy_reg;
    logic [CW-1:0]             cnt_reg;
    logic [31:0]               rem_reg;
    logic [31:0]               dsr_reg;
    logic [ztp_pkg::DVD_W-1:0] dvd_reg;
    logic                      done_reg;
    logic [32:0]               trial;
    logic                      fits;

    // The dividend shifts out at the top while quotient bits shift in below.
    assign trial = {rem_reg, dvd_reg[ztp_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ztp_pkg::DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
            dvd_reg <= {dvd_reg[ztp_pkg::DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- hdl/ztp_blend.sv -----
// Bit-serial moving-average blend: one bit of alpha per cycle, rounded at the end.
module ztp_blend
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ztp_pkg::MS_W-1:0]      ema,
    input  logic [ztp_pkg::MS_W-1:0]      ms,
    input  logic [ztp_pkg::ALPHA_W-1:0]   alpha,
    output logic                          done,
    output logic [ztp_pkg::MS_W-1:0]      result
);

    localparam int unsigned AW = ztp_pkg::ALPHA_W;
    localparam int unsigned CW = $clog2(AW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] a_reg;
    logic [AW-1:0] b_reg;
    logic [47:0]   ms_sh_reg;
    logic [47:0]   ema_sh_reg;
    logic [47:0]   sum_reg;
    logic [47:0]   rounded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(AW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg      <= alpha;
            b_reg      <= AW'(ztp_pkg::ALPHA_ONE - alpha);
            ms_sh_reg  <= 48'(ms);
            ema_sh_reg <= 48'(ema);
            sum_reg    <= '0;
        end
        else if (busy_reg)
        begin
            sum_reg    <= sum_reg + (a_reg[0] ? ms_sh_reg : 48'd0)
                                  + (b_reg[0] ? ema_sh_reg : 48'd0);
            a_reg      <= a_reg >> 1;
            b_reg      <= b_reg >> 1;
            ms_sh_reg  <= ms_sh_reg << 1;
            ema_sh_reg <= ema_sh_reg << 1;
        end
    end

    assign rounded = sum_reg + 48'd32768;
    assign done    = done_reg;
    assign result  = rounded[47:16];

endmodule

// ----- hdl/zone_time_profiler_ema_top.sv -----
// Top level of the per-zone time profiler with moving-average reporting.
//
// Zone begin and end words go through the 64-bit serial divider that forms the
// zone fraction; when the zone is out of range or the total average is zero the
// division is skipped. A frame-done word first sums the accumulators. Then, for
// each zone, it runs the serial division to milliseconds. After the first frame
// a 17-bit serial blend follows. The fraction division comes last. One word is
// processed at a time; the finished result sits in an output register so that
// the next word may be taken while it waits. A disabled profiler answers without
// any division and leaves all state untouched.
module zone_time_profiler_ema_top
#(
    parameter int unsigned NUM_ZONES  = 6,
    parameter int unsigned TOTAL_ZONE = 5
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // zone[3:0], timestamp[35:4]
    input  logic [1:0]                  s_tuser,   // req_type[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [55:0]                 m_tdata,   // zone_ms[31:0], zone_fraction[48:32]
    output logic [1:0]                  m_tuser,   // status[1:0]
    input  logic                        cfg_we,
    input  logic [ztp_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [ztp_pkg::CFG_DW-1:0]  cfg_wdata
);

    localparam int unsigned ZW        = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam bit          HAS_TOTAL = TOTAL_ZONE < NUM_ZONES;
    localparam logic [ZW-1:0] TOT_IDX = ZW'(TOTAL_ZONE % NUM_ZONES);
    localparam logic [ZW-1:0] LAST_IDX = ZW'(NUM_ZONES - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_EXEC   = 9'b000000010,
        S_SUM    = 9'b000000100,
        S_CONV   = 9'b000001000,
        S_CONVW  = 9'b000010000,
        S_BLENDW = 9'b000100000,
        S_FRAC   = 9'b001000000,
        S_FRACW  = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg;

    logic                              enable_reg;
    logic [31:0]                       tps_reg;
    logic [ztp_pkg::ALPHA_W-1:0]       alpha_reg;

    ztp_pkg::req_t                     req_reg;
    logic [ztp_pkg::ZONE_W-1:0]        zone_reg;
    logic [ztp_pkg::TS_W-1:0]          ts_reg;

    logic [31:0]                       start_reg  [NUM_ZONES];
    logic [31:0]                       acc_reg    [NUM_ZONES];
    logic [31:0]                       avg_reg    [NUM_ZONES];
    logic [NUM_ZONES-1:0]              active_reg;
    logic                              first_reg;

    logic [ZW-1:0]                     idx_reg;
    logic [31:0]                       sum_reg;
    ztp_pkg::status_t                  status_reg;
    logic [ztp_pkg::MS_W-1:0]          zms_reg;
    logic [ztp_pkg::FRAC_W-1:0]        frac_reg;

    logic                              m_tvalid_reg;
    ztp_pkg::status_t                  m_status_reg;
    logic [ztp_pkg::MS_W-1:0]          m_ms_reg;
    logic [ztp_pkg::FRAC_W-1:0]        m_frac_reg;

    logic                              in_range;
    logic [ZW-1:0]                     zi;
    logic [31:0]                       tps_eff;
    logic [ztp_pkg::ALPHA_W-1:0]       alpha_eff;
    logic [31:0]                       total_avg;
    logic [41:0]                       acc_x1000;
    logic [ztp_pkg::DVD_W-1:0]         ms_num;
    logic [ztp_pkg::DVD_W-1:0]         frac_num;
    logic [31:0]                       sum_next;
    logic [31:0]                       ms_sat;

    logic                              div_start;
    logic [ztp_pkg::DVD_W-1:0]         div_dividend;
    logic [31:0]                       div_divisor;
    logic                              div_done;
    logic [ztp_pkg::DVD_W-1:0]         div_q;
    logic                              blend_start;
    logic                              blend_done;
    logic [ztp_pkg::MS_W-1:0]          blend_result;

    assign in_range  = {1'b0, zone_reg} < 5'(NUM_ZONES);
    assign zi        = zone_reg[ZW-1:0];
    assign tps_eff   = (tps_reg == 32'd0) ? 32'd1 : tps_reg;
    assign alpha_eff = (alpha_reg > ztp_pkg::ALPHA_ONE) ? ztp_pkg::ALPHA_ONE : alpha_reg;
    assign total_avg = HAS_TOTAL ? avg_reg[TOT_IDX] : 32'd0;

    // acc * 1000 as shifts: 1024 - 16 - 8.
    assign acc_x1000 = {acc_reg[idx_reg], 10'd0} - 42'({acc_reg[idx_reg], 4'd0})
                     - 42'({acc_reg[idx_reg], 3'd0});
    assign ms_num    = 64'({acc_x1000, 16'd0}) + 64'(tps_eff[31:1]);
    assign frac_num  = {16'd0, avg_reg[zi], 16'd0};
    assign sum_next  = sum_reg + ((idx_reg != TOT_IDX) ? acc_reg[idx_reg] : 32'd0);
    assign ms_sat    = (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];

    assign div_start    = (state_reg == S_CONV)
                        || ((state_reg == S_FRAC) && in_range && (total_avg != 32'd0));
    assign div_dividend = (state_reg == S_FRAC) ? frac_num : ms_num;
    assign div_divisor  = (state_reg == S_FRAC) ? total_avg : tps_eff;
    assign blend_start  = (state_reg == S_CONVW) && div_done && !first_reg;

    ztp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    ztp_blend u_blend
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (blend_start),
        .ema    (avg_reg[idx_reg]),
        .ms     (ms_sat),
        .alpha  (alpha_eff),
        .done   (blend_done),
        .result (blend_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            tps_reg    <= ztp_pkg::TPS_RESET;
            alpha_reg  <= ztp_pkg::ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ztp_pkg::REG_ENABLE: enable_reg <= cfg_wdata[0];
                ztp_pkg::REG_TPS:    tps_reg    <= cfg_wdata;
                ztp_pkg::REG_ALPHA:  alpha_reg  <= cfg_wdata[ztp_pkg::ALPHA_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            first_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
            m_status_reg <= ztp_pkg::ST_OK;
            m_ms_reg     <= '0;
            m_frac_reg   <= '0;
            status_reg   <= ztp_pkg::ST_OK;
            zms_reg      <= '0;
            frac_reg     <= '0;
            sum_reg      <= '0;
            idx_reg      <= '0;
            for (int i = 0; i < NUM_ZONES; i++)
            begin
                start_reg[i] <= '0;
                acc_reg[i]   <= '0;
                avg_reg[i]   <= '0;
            end
        end
        else
        begin
            // The output register is only emptied here when no new word loads it.
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (!enable_reg)
                    begin
                        status_reg <= ztp_pkg::ST_DISABLED;
                        zms_reg    <= '0;
                        frac_reg   <= '0;
                        state_reg  <= S_OUT;
                    end
                    else if (req_reg == ztp_pkg::REQ_FRAME)
                    begin
                        status_reg <= ztp_pkg::ST_OK;
                        idx_reg    <= '0;
                        sum_reg    <= '0;
                        state_reg  <= S_SUM;
                    end
                    else
                    begin
                        if (in_range && (req_reg == ztp_pkg::REQ_END) && !active_reg[zi])
                        begin
                            status_reg <= ztp_pkg::ST_NO_BEGIN;
                        end
                        else
                        begin
                            status_reg <= ztp_pkg::ST_OK;
                        end
                        if (in_range && (req_reg == ztp_pkg::REQ_BEGIN))
                        begin
                            start_reg[zi]  <= ts_reg;
                            active_reg[zi] <= 1'b1;
                        end
                        else if (in_range && (req_reg == ztp_pkg::REQ_END) && active_reg[zi])
                        begin
                            acc_reg[zi]    <= acc_reg[zi] + (ts_reg - start_reg[zi]);
                            active_reg[zi] <= 1'b0;
                        end
                        state_reg <= S_FRAC;
                    end
                end
                S_SUM:
                begin
                    sum_reg <= sum_next;
                    if (idx_reg == LAST_IDX)
                    begin
                        if (HAS_TOTAL)
                        begin
                            acc_reg[TOT_IDX] <= sum_next;
                        end
                        idx_reg   <= '0;
                        state_reg <= S_CONV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_CONV:
                begin
                    state_reg <= S_CONVW;
                end
                S_CONVW:
                begin
                    if (div_done)
                    begin
                        if (first_reg)
                        begin
                            avg_reg[idx_reg]    <= ms_sat;
                            acc_reg[idx_reg]    <= '0;
                            active_reg[idx_reg] <= 1'b0;
                            if (idx_reg == LAST_IDX)
                            begin
                                first_reg <= 1'b0;
                                state_reg <= S_FRAC;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_CONV;
                            end
                        end
                        else
                        begin
                            state_reg <= S_BLENDW;
                        end
                    end
                end
                S_BLENDW:
                begin
                    if (blend_done)
                    begin
                        avg_reg[idx_reg]    <= blend_result;
                        acc_reg[idx_reg]    <= '0;
                        active_reg[idx_reg] <= 1'b0;
                        if (idx_reg == LAST_IDX)
                        begin
                            first_reg <= 1'b0;
                            state_reg <= S_FRAC;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_CONV;
                        end
                    end
                end
                S_FRAC:
                begin
                    frac_reg <= '0;
                    if (!in_range)
                    begin
                        status_reg <= ztp_pkg::ST_RANGE;
                        zms_reg    <= '0;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        zms_reg   <= avg_reg[zi];
                        state_reg <= (total_avg != 32'd0) ? S_FRACW : S_OUT;
                    end
                end
                S_FRACW:
                begin
                    if (div_done)
                    begin
                        frac_reg  <= (div_q > 64'(ztp_pkg::FRAC_ONE))
                                   ? ztp_pkg::FRAC_ONE : div_q[ztp_pkg::FRAC_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= status_reg;
                        m_ms_reg     <= zms_reg;
                        m_frac_reg   <= frac_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Input word is captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg  <= ztp_pkg::req_t'(s_tuser);
            zone_reg <= s_tdata[3:0];
            ts_reg   <= s_tdata[35:4];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_frac_reg, m_ms_reg};

endmodule

// ----- test/zone_time_profiler_ema_checker.sv -----
// Checker for the zone time profiler: predicts every result word and compares it.
module zone_time_profiler_ema_checker
#(
    parameter int unsigned NUM_ZONES  = 6,
    parameter int unsigned TOTAL_ZONE = 5
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // zone[3:0], timestamp[35:4]
    input  logic [1:0]                  s_tuser,   // req_type[1:0]
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [55:0]                 m_tdata,   // zone_ms[31:0], zone_fraction[48:32]
    input  logic [1:0]                  m_tuser,   // status[1:0]
    input  logic                        cfg_we,
    input  logic [ztp_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [ztp_pkg::CFG_DW-1:0]  cfg_wdata,
    output int                          errors,
    output int                          pending
);

    typedef struct packed {
        ztp_pkg::status_t                   status;
        logic [ztp_pkg::MS_W-1:0]           zone_ms;
        logic [ztp_pkg::FRAC_W-1:0]         fraction;
    } zone_report_t;

    zone_report_t      report_q[$];

    logic              prof_enable;
    logic [31:0]       prof_tps;
    logic [16:0]       prof_alpha;
    logic [31:0]       start_ts[16];
    logic [31:0]       acc_ticks[16];
    logic [31:0]       avg_ms[16];
    logic              active[16];
    logic              first_frame;

    function automatic logic [31:0] ticks_to_ms(logic [31:0] acc);
        logic [63:0] tps;
        logic [63:0] quot;
        begin
            tps  = (prof_tps == 32'd0) ? 64'd1 : {32'd0, prof_tps};
            quot = ({32'd0, acc} * 64'd1000 * 64'd65536 + tps / 64'd2) / tps;
            ticks_to_ms = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        end
    endfunction

    function automatic zone_report_t profile_event(ztp_pkg::req_t req, logic [3:0] zone,
                                                   logic [31:0] ts);
        zone_report_t rep;
        logic [63:0]  alpha;
        logic [63:0]  blend;
        logic [63:0]  total;
        logic [63:0]  frac;
        logic [31:0]  sum;
        logic [31:0]  ms;
        logic         in_range;
        begin
            rep      = '{status: ztp_pkg::ST_DISABLED, zone_ms: '0, fraction: '0};
            in_range = zone < NUM_ZONES;
            if (prof_enable) begin
                rep.status = ztp_pkg::ST_OK;
                if (req == ztp_pkg::REQ_FRAME) begin
                    alpha = (prof_alpha > ztp_pkg::ALPHA_ONE) ? 64'd65536
                                                              : {47'd0, prof_alpha};
                    if (TOTAL_ZONE < NUM_ZONES) begin
                        sum = '0;
                        for (int i = 0; i < NUM_ZONES; i++)
                            if (i != TOTAL_ZONE)
                                sum += acc_ticks[i];
                        acc_ticks[TOTAL_ZONE] = sum;
                    end
                    for (int i = 0; i < NUM_ZONES; i++) begin
                        ms = ticks_to_ms(acc_ticks[i]);
                        if (first_frame)
                            avg_ms[i] = ms;
                        else begin
                            blend = {32'd0, avg_ms[i]} * (64'd65536 - alpha)
                                    + {32'd0, ms} * alpha + 64'd32768;
                            avg_ms[i] = blend[47:16];
                        end
                        acc_ticks[i] = '0;
                        active[i]    = 1'b0;
                    end
                    first_frame = 1'b0;
                end
                else if (in_range && req == ztp_pkg::REQ_BEGIN) begin
                    start_ts[zone] = ts;
                    active[zone]   = 1'b1;
                end
                else if (in_range && req == ztp_pkg::REQ_END) begin
                    if (active[zone]) begin
                        acc_ticks[zone] += ts - start_ts[zone];
                        active[zone]     = 1'b0;
                    end
                    else
                        rep.status = ztp_pkg::ST_NO_BEGIN;
                end
                if (!in_range)
                    rep.status = ztp_pkg::ST_RANGE;
                else begin
                    rep.zone_ms = avg_ms[zone];
                    total = (TOTAL_ZONE < NUM_ZONES) ? {32'd0, avg_ms[TOTAL_ZONE]} : 64'd0;
                    frac  = 64'd0;
                    if (total != 64'd0) begin
                        frac = ({32'd0, avg_ms[zone]} << 16) / total;
                        if (frac > 64'd65536)
                            frac = 64'd65536;
                    end
                    rep.fraction = frac[16:0];
                end
            end
            profile_event = rep;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        zone_report_t exp_rep;
        zone_report_t got;
        if (!rst_n) begin
            prof_enable = 1'b0;
            prof_tps    = ztp_pkg::TPS_RESET;
            prof_alpha  = ztp_pkg::ALPHA_RESET;
            for (int i = 0; i < 16; i++) begin
                start_ts[i]  = '0;
                acc_ticks[i] = '0;
                avg_ms[i]    = '0;
                active[i]    = 1'b0;
            end
            first_frame = 1'b1;
            report_q.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got = '{status: ztp_pkg::status_t'(m_tuser), zone_ms: m_tdata[31:0],
                        fraction: m_tdata[48:32]};
                if (report_q.size() == 0) begin
                    $display("%0t: result word with none expected: %p", $time, got);
                    errors++;
                end
                else begin
                    exp_rep = report_q.pop_front();
                    if (got.status !== exp_rep.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_rep.status, got.status);
                        errors++;
                    end
                    if (got.zone_ms !== exp_rep.zone_ms) begin
                        $display("%0t: zone_ms expected %h actual %h",
                                 $time, exp_rep.zone_ms, got.zone_ms);
                        errors++;
                    end
                    if (got.fraction !== exp_rep.fraction) begin
                        $display("%0t: zone_fraction expected %h actual %h",
                                 $time, exp_rep.fraction, got.fraction);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                report_q.push_back(profile_event(ztp_pkg::req_t'(s_tuser), s_tdata[3:0],
                                                 s_tdata[35:4]));
            if (cfg_we) begin
                if (cfg_addr == ztp_pkg::REG_ENABLE)
                    prof_enable = cfg_wdata[0];
                else if (cfg_addr == ztp_pkg::REG_TPS)
                    prof_tps = cfg_wdata;
                else if (cfg_addr == ztp_pkg::REG_ALPHA)
                    prof_alpha = cfg_wdata[16:0];
            end
            pending = report_q.size();
        end
    end

endmodule

// ----- test/zone_time_profiler_ema_top_tb.sv -----
// Testbench top for the zone time profiler: stimulus, configuration and verdict.
module zone_time_profiler_ema_top_tb;

    localparam int unsigned NZ         = 6;
    localparam int unsigned TZ         = 5;
    localparam int          STALL_MAX  = 40000;
    localparam int          SETTLE     = 800;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [39:0]                 s_tdata;
    logic [1:0]                  s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [55:0]                 m_tdata;
    logic [1:0]                  m_tuser;
    logic                        cfg_we;
    logic [ztp_pkg::CFG_AW-1:0]  cfg_addr;
    logic [ztp_pkg::CFG_DW-1:0]  cfg_wdata;
    int                          errors;
    int                          pending;

    int                          send_idle;
    int                          recv_idle;
    int                          stall_cycles;
    logic                        open_zone[NZ];
    logic [31:0]                 open_ts[NZ];
    logic [31:0]                 now_ts;

    zone_time_profiler_ema_top #(.NUM_ZONES(NZ), .TOTAL_ZONE(TZ)) dut (.*);

    zone_time_profiler_ema_checker #(.NUM_ZONES(NZ), .TOTAL_ZONE(TZ)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle);

    // Ends the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_MAX) begin
            $display("** zone_time_profiler_ema_top: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_word(ztp_pkg::req_t req, logic [3:0] zone, logic [31:0] ts);
        begin
            if ($urandom_range(0, 99) < send_idle) begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(0, 99) < send_idle);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= req;
            s_tdata  <= {4'd0, ts, zone};
            do
                @(posedge clk);
            while (!s_tready);
        end
    endtask

    task automatic drain_results();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [ztp_pkg::CFG_AW-1:0] addr, logic [31:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addr;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // Mostly properly paired begin and end words on valid zones, with frame
    // boundaries, plus some arbitrary words.
    task automatic random_events(int count);
        int       sel;
        int       z;
        begin
            for (int n = 0; n < count; n++) begin
                sel = $urandom_range(0, 99);
                z   = $urandom_range(0, NZ - 1);
                if (sel < 9)
                    send_word(ztp_pkg::REQ_FRAME, 4'($urandom_range(0, 15)), $urandom);
                else if (sel < 85) begin
                    if (!open_zone[z]) begin
                        open_ts[z]   = ($urandom_range(0, 9) == 0) ? $urandom : now_ts;
                        open_zone[z] = 1'b1;
                        send_word(ztp_pkg::REQ_BEGIN, 4'(z), open_ts[z]);
                    end
                    else begin
                        open_zone[z] = 1'b0;
                        send_word(ztp_pkg::REQ_END, 4'(z), open_ts[z] +
                                  (($urandom_range(0, 19) == 0) ? $urandom
                                                               : $urandom_range(0, 3000000)));
                    end
                    now_ts += $urandom_range(0, 300000);
                end
                else
                    send_word(ztp_pkg::req_t'($urandom_range(0, 3)),
                              4'($urandom_range(0, 15)), $urandom);
            end
            for (int i = 0; i < NZ; i++)
                open_zone[i] = 1'b0;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = ztp_pkg::REG_ENABLE;
        cfg_wdata    = '0;
        stall_cycles = 0;
        send_idle    = 10;
        recv_idle    = 66;
        now_ts       = '0;
        for (int i = 0; i < NZ; i++)
            open_zone[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled after reset: every word gets the disabled status and changes no state.
        send_word(ztp_pkg::REQ_BEGIN, 4'd0, 32'd100);
        send_word(ztp_pkg::REQ_FRAME, 4'd15, 32'hFFFF_FFFF);
        drain_results();
        write_reg(ztp_pkg::REG_ENABLE, 32'd1);

        // Directed words with the reset tick rate and alpha.
        send_word(ztp_pkg::REQ_END, 4'd1, 32'd5);
        send_word(ztp_pkg::REQ_BEGIN, 4'd0, 32'd0);
        send_word(ztp_pkg::REQ_END, 4'd0, 32'hFFFF_FFFF);
        send_word(ztp_pkg::REQ_BEGIN, 4'd2, 32'hFFFF_FFF0);
        send_word(ztp_pkg::REQ_END, 4'd2, 32'h0000_0010);
        send_word(ztp_pkg::REQ_BEGIN, 4'd15, 32'd7);
        send_word(ztp_pkg::REQ_END, 4'd6, 32'd7);
        send_word(ztp_pkg::REQ_UNUSED, 4'd2, 32'hA5A5_A5A5);
        send_word(ztp_pkg::REQ_BEGIN, 4'd3, 32'd1000);
        send_word(ztp_pkg::REQ_END, 4'd3, 32'd47000);
        send_word(ztp_pkg::REQ_FRAME, 4'd2, 32'd0);
        send_word(ztp_pkg::REQ_BEGIN, 4'd5, 32'd10);
        send_word(ztp_pkg::REQ_END, 4'd5, 32'd2000000);
        send_word(ztp_pkg::REQ_BEGIN, 4'd4, 32'd0);
        send_word(ztp_pkg::REQ_END, 4'd4, 32'd4687500);
        send_word(ztp_pkg::REQ_FRAME, 4'd15, 32'h5A5A_5A5A);
        send_word(ztp_pkg::REQ_END, 4'd4, 32'd1);
        send_word(ztp_pkg::REQ_FRAME, 4'd5, 32'd0);
        send_word(ztp_pkg::REQ_UNUSED, 4'd9, 32'd0);
        drain_results();

        write_reg(ztp_pkg::REG_TPS, $urandom_range(1000, 100000000));
        write_reg(ztp_pkg::REG_ALPHA, $urandom_range(0, 65536));
        random_events(325);
        // Hold off until the block has answered everything in flight.
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        random_events(325);
        drain_results();

        send_idle = 66;
        recv_idle = 10;
        write_reg(ztp_pkg::REG_TPS, 32'd0);
        write_reg(ztp_pkg::REG_ALPHA, 32'h0001_FFFF);
        random_events(650);
        drain_results();

        send_idle = 0;
        recv_idle = 0;
        write_reg(ztp_pkg::REG_TPS, 32'hFFFF_FFFF);
        write_reg(ztp_pkg::REG_ALPHA, 32'd0);
        random_events(300);
        drain_results();
        write_reg(ztp_pkg::REG_TPS, 32'd1);
        write_reg(ztp_pkg::REG_ALPHA, 32'd65536);
        random_events(300);
        drain_results();

        // Disabling must leave the state intact for when it is re-enabled.
        write_reg(ztp_pkg::REG_ENABLE, 32'd0);
        random_events(15);
        drain_results();
        write_reg(ztp_pkg::REG_ENABLE, 32'hFFFF_FFFF);
        write_reg(ztp_pkg::REG_TPS, 32'd46875000);
        random_events(20);
        drain_results();

        if (errors == 0)
            $display("** zone_time_profiler_ema_top: PASSED **");
        else
            $display("** zone_time_profiler_ema_top: FAILED **");
        $finish;
    end

endmodule

// ----- zone_time_profiler_ema_top.f -----
hdl/ztp_pkg.sv
hdl/ztp_div.sv
hdl/ztp_blend.sv
hdl/zone_time_profiler_ema_top.sv
test/zone_time_profiler_ema_checker.sv
test/zone_time_profiler_ema_top_tb.sv
